// File: hw/rtl/hffu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hffu_pkg: shared types, constants and tables of the hex frame unpacker
// Holds the field table, the hex digit decoder and the job record that
// travels from the parser to the byte expander.
// ----------------------------------------------------------------------------
`default_nettype none

package hffu_pkg;

  // Framing characters.
  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE   = 8'h03;

  // Field table layout.
  localparam logic [4:0] SEG_COUNT = 5'd24;
  localparam logic [4:0] RAW_SEG   = 5'd1;
  localparam logic [4:0] DIST_SEG  = 5'd22;

  // Distance repeat count limits.
  localparam int         MAX_POINTS = 2048;
  localparam logic [11:0] DIST_RESET = 12'd1081;

  // Register map.
  localparam logic REG_DIST_COUNT = 1'b0;

  // Job queue depth.
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_END_OK    = 2'd1,
    KIND_END_SHORT = 2'd2
  } kind_t;

  // One unit of work for the back end: a value sent as nbytes bytes.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [2:0]  nbytes;
  } job_t;

  // Number of hex nibbles in each field of a segment.
  function automatic logic [3:0] seg_nibbles(input logic [4:0] seg);
    logic [3:0] w;
    unique case (seg)
      5'd0, 5'd16, 5'd22, 5'd23: w = 4'd4;
      5'd2, 5'd4, 5'd6, 5'd20:   w = 4'd2;
      5'd17:                     w = 4'd8;
      default:                   w = 4'd1;
    endcase
    return w;
  endfunction

  // Fixed repeat count of a segment (the distance segment is set by register).
  function automatic logic [2:0] seg_repeats(input logic [4:0] seg);
    logic [2:0] r;
    unique case (seg)
      5'd1, 5'd10:                     r = 3'd4;
      5'd8, 5'd12, 5'd14, 5'd21:       r = 3'd5;
      5'd9, 5'd11, 5'd13, 5'd15:       r = 3'd3;
      5'd22:                           r = 3'd0;
      default:                         r = 3'd1;
    endcase
    return r;
  endfunction

  // Hex digit decode: bit 4 set when the character is a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b1, 4'(c - 8'h57)};
    end else begin
      d = 5'd0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hex_frame_field_unpacker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_frame_field_unpacker: ASCII hex scanner frame unpacker
// Parses framed ASCII hex fields and emits their binary bytes.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on in_byte with push; a beat is taken when push is high
// and full is low. 0x02 opens a frame, 0x03 closes it with an end result.
// Results leave as a queue: while empty is low, out_byte, out_kind and
// out_last hold the oldest result, and pop takes it. out_last marks the
// final result caused by one input beat. out_kind is 0 for data bytes,
// 1 for a complete frame end and 2 for a short frame end.
// A taken beat's job goes via the job queue to the output register. Beats
// are taken one per cycle while full is low; the expander gives one result
// byte per cycle while no result waits unpopped, and a finished field of up
// to eight nibbles gives up to four bytes. A four-entry job queue sits
// between parser and expander; when it fills, full goes high. A stalled
// receiver simply holds the output register, backs up the queue and then
// raises full. Reset clears the frame state, empties the queue and output,
// and sets the distance count register (APB, byte address 0) to 1081.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_frame_field_unpacker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_kind,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import hffu_pkg::*;

  logic        take;
  logic [11:0] dist_count_r;
  logic        job_valid;
  job_t        job;
  job_t        head;
  logic        q_valid;
  logic        q_full;
  logic        q_pop;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIST_COUNT) ? {20'd0, dist_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_count_r <= DIST_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DIST_COUNT) begin
      dist_count_r <= pwdata[11:0];
    end
  end

  // Input beat accepted while the job queue has room.
  assign full = q_full;
  assign take = push && !q_full;

  hffu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .in_byte        (in_byte),
    .distance_count (dist_count_r),
    .job_valid      (job_valid),
    .job            (job)
  );

  hffu_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_valid),
    .wr_job  (job),
    .rd_en   (q_pop),
    .rd_job  (head),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  hffu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head     (head),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .out_kind (out_kind),
    .out_last (out_last)
  );

  // An end result is always the only result of its beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_DATA) |-> out_last)
    else $error("end result without last flag");

  // An end result carries a zero byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != KIND_DATA) |-> (out_byte == 8'd0))
    else $error("end result with nonzero byte");

  // The queue never takes a job while full.
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !q_pop) |-> !job_valid)
    else $error("job queue overflow");

  // Nothing is shown right after reset.
  assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result visible after reset");

endmodule

`default_nettype wire

// File: hw/rtl/hffu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hffu_front: frame parser
// Tracks the frame state, walks the field table, gathers hex nibbles and
// issues one job per finished field, raw character or frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module hffu_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  input  wire logic [7:0]       in_byte,
  input  wire logic [11:0]      distance_count,
  output logic                  job_valid,
  output hffu_pkg::job_t        job
);
  import hffu_pkg::*;

  logic        frame_open_r, frame_open_nxt;
  logic [4:0]  seg_r, seg_nxt;
  logic [11:0] rep_r, rep_nxt;
  logic [3:0]  nib_r, nib_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        bad_r, bad_nxt;

  logic [11:0] dist_sat;
  logic [11:0] seg_reps;
  logic [11:0] rep_inc;
  logic [4:0]  seg_inc;
  logic [4:0]  seg_after;
  logic [3:0]  width;
  logic [4:0]  digit;
  logic [31:0] acc_new;
  logic        bad_new;
  logic [3:0]  nib_new;
  logic [4:0]  width_up;

  // Repeat count of the current segment and the segment that follows it.
  always_comb begin
    dist_sat  = (distance_count > 12'(MAX_POINTS)) ? 12'(MAX_POINTS) : distance_count;
    seg_reps  = (seg_r == DIST_SEG) ? dist_sat : {9'd0, seg_repeats(seg_r)};
    rep_inc   = rep_r + 12'd1;
    seg_inc   = seg_r + 5'd1;
    seg_after = (seg_inc == DIST_SEG && dist_sat == 12'd0) ? seg_inc + 5'd1 : seg_inc;
    width     = seg_nibbles(seg_r);
    width_up  = {1'b0, width} + 5'd1;
    digit     = hex_digit(in_byte);
    acc_new   = digit[4] ? {acc_r[27:0], digit[3:0]} : acc_r;
    bad_new   = bad_r | ~digit[4];
    nib_new   = nib_r + 4'd1;
  end

  // Next state and job generation for one accepted beat.
  always_comb begin
    frame_open_nxt = frame_open_r;
    seg_nxt        = seg_r;
    rep_nxt        = rep_r;
    nib_nxt        = nib_r;
    acc_nxt        = acc_r;
    bad_nxt        = bad_r;
    job_valid      = 1'b0;
    job.kind       = KIND_DATA;
    job.value      = 32'd0;
    job.nbytes     = 3'd1;
    if (take) begin
      if (in_byte == START_BYTE) begin
        frame_open_nxt = 1'b1;
        seg_nxt        = 5'd0;
        rep_nxt        = 12'd0;
        nib_nxt        = 4'd0;
        acc_nxt        = 32'd0;
        bad_nxt        = 1'b0;
      end else if (frame_open_r) begin
        if (in_byte == END_BYTE) begin
          job_valid      = 1'b1;
          job.kind       = (seg_r >= SEG_COUNT) ? KIND_END_OK : KIND_END_SHORT;
          frame_open_nxt = 1'b0;
          nib_nxt        = 4'd0;
          acc_nxt        = 32'd0;
          bad_nxt        = 1'b0;
        end else if (seg_r < SEG_COUNT) begin
          if (seg_r == RAW_SEG) begin
            job_valid = 1'b1;
            job.value = {24'd0, in_byte};
          end else if (nib_new >= width) begin
            job_valid  = 1'b1;
            job.value  = bad_new ? 32'd0 : acc_new;
            job.nbytes = width_up[3:1];
          end
          if (job_valid) begin
            // Field finished: clear the gatherer and step the table.
            nib_nxt = 4'd0;
            acc_nxt = 32'd0;
            bad_nxt = 1'b0;
            if (rep_inc >= seg_reps) begin
              seg_nxt = seg_after;
              rep_nxt = 12'd0;
            end else begin
              rep_nxt = rep_inc;
            end
          end else begin
            nib_nxt = nib_new;
            acc_nxt = acc_new;
            bad_nxt = bad_new;
          end
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      seg_r        <= 5'd0;
      rep_r        <= 12'd0;
      nib_r        <= 4'd0;
      acc_r        <= 32'd0;
      bad_r        <= 1'b0;
    end else begin
      frame_open_r <= frame_open_nxt;
      seg_r        <= seg_nxt;
      rep_r        <= rep_nxt;
      nib_r        <= nib_nxt;
      acc_r        <= acc_nxt;
      bad_r        <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hffu_jobq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hffu_jobq: job queue
// A short first-in first-out queue of jobs between the parser and the
// byte expander, so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module hffu_jobq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire hffu_pkg::job_t wr_job,
  input  wire logic           rd_en,
  output hffu_pkg::job_t      rd_job,
  output logic                q_valid,
  output logic                q_full
);
  import hffu_pkg::*;

  job_t                 slots [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [JOBQ_AW:0]     count_r;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == (JOBQ_AW+1)'(JOBQ_DEPTH));
  assign rd_job  = slots[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr_r] <= wr_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + JOBQ_AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + JOBQ_AW'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + (JOBQ_AW+1)'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - (JOBQ_AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hffu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hffu_back: byte expander
// Splits the job at the head of the queue into little-endian bytes, one per
// cycle while no result waits unpopped, into an output register that the
// receiver pops.
`default_nettype none

module hffu_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire hffu_pkg::job_t head,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output logic [7:0]          out_byte,
  output logic [1:0]          out_kind,
  output logic                out_last
);
  import hffu_pkg::*;

  logic        out_valid_r;
  logic [7:0]  byte_r;
  kind_t       kind_r;
  logic        last_r;
  logic [1:0]  idx_r;
  logic        load;
  logic        is_last;
  logic [7:0]  sel_byte;

  assign empty    = ~out_valid_r;
  assign out_byte = byte_r;
  assign out_kind = kind_r;
  assign out_last = last_r;

  // Pick the current byte of the head job.
  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head.value[7:0];
      2'd1:    sel_byte = head.value[15:8];
      2'd2:    sel_byte = head.value[23:16];
      default: sel_byte = head.value[31:24];
    endcase
    load    = q_valid && (!out_valid_r || pop);
    is_last = ({1'b0, idx_r} == head.nbytes - 3'd1);
    q_pop   = load && is_last;
  end

  // Byte index within the head job and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= sel_byte;
      kind_r <= head.kind;
      last_r <= is_last;
    end
  end

endmodule

`default_nettype wire
